>>> rtl/core/svpwm_duty_modulator_macros.svh
// ----------------------------------------------------------------------------
// SVPWM duty modulator assertion macros
// Shared concurrent assertion forms for the modulator RTL.
// ----------------------------------------------------------------------------
`ifndef SVPWM_DUTY_MODULATOR_MACROS_SVH
`define SVPWM_DUTY_MODULATOR_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define SVPWM_ASSERT_HOLDS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// A condition in one cycle that implies another in the next cycle.
`define SVPWM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/svpwm_pkg.sv
// ----------------------------------------------------------------------------
// SVPWM duty modulator package
// Widths, fixed-point constants and pipeline sideband types.
// ----------------------------------------------------------------------------
package svpwm_pkg;

   // Field and internal widths.
   localparam int IN_W      = 16;
   localparam int DUTY_W    = 16;
   localparam int CEIL_W    = 16;
   localparam int BUS_W     = 15;
   localparam int PHASE_W   = 33;
   localparam int SPAN_W    = 33;
   localparam int AVAIL_W   = 32;
   localparam int SCALE_Q_W = 15;
   localparam int DUTY_Q_W  = 16;
   localparam int PROD_W    = 49;
   localparam int LANES     = 3;

   // Q1.15 one and one half.
   localparam logic [DUTY_W-1:0] Q15_ONE  = 16'd32768;
   localparam logic [DUTY_W-1:0] Q15_HALF = 16'd16384;

   // sqrt(3)/2 in Q.16.
   localparam logic signed [16:0] SQRT3_HALF_Q16 = 17'sd56756;

   typedef logic signed [PHASE_W-1:0] phase_type;
   typedef logic [SPAN_W-1:0]         span_type;

   // Data that rides along the scale divider.
   typedef struct packed {
      logic                              need_scale;
      logic [LANES-1:0][SPAN_W-1:0]      diff;
      logic [BUS_W-1:0]                  bus;
      logic                              bus_invalid;
      logic [CEIL_W-1:0]                 ceiling;
   } scale_side_type;

   // Data that rides along the duty dividers.
   typedef struct packed {
      logic [DUTY_W-1:0] scale;
      logic              bus_invalid;
      logic [CEIL_W-1:0] ceiling;
   } duty_side_type;

   localparam int SCALE_SIDE_W = $bits(scale_side_type);
   localparam int DUTY_SIDE_W  = $bits(duty_side_type);

endpackage

>>> rtl/core/svpwm_div_pipe.sv
// ----------------------------------------------------------------------------
// SVPWM pipelined restoring divider
// One quotient bit per register stage for several lanes that share a divisor,
// with a valid bit and a sideband word traveling alongside.
// ----------------------------------------------------------------------------
module svpwm_div_pipe #(
   parameter int LANES = svpwm_pkg::LANES,
   parameter int DW    = svpwm_pkg::BUS_W,
   parameter int QW    = svpwm_pkg::DUTY_Q_W,
   parameter int SW    = svpwm_pkg::DUTY_SIDE_W
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  logic [LANES-1:0][DW-1:0]    in_rem,
   input  logic [LANES-1:0][QW-1:0]    in_low,
   input  logic [DW-1:0]               in_divisor,
   input  logic [SW-1:0]               in_side,
   output logic                        out_valid,
   output logic [LANES-1:0][QW-1:0]    out_quot,
   output logic [SW-1:0]               out_side
);

   // Stage registers: partial remainder, dividend bits / quotient bits.
   logic [QW-1:0]                valid_ff;
   logic [LANES-1:0][DW-1:0]     rem_ff  [QW];
   logic [LANES-1:0][QW-1:0]     low_ff  [QW];
   logic [DW-1:0]                div_ff  [QW];
   logic [SW-1:0]                side_ff [QW];

   logic [QW-1:0]                valid_src;
   logic [LANES-1:0][DW-1:0]     rem_src  [QW];
   logic [LANES-1:0][QW-1:0]     low_src  [QW];
   logic [DW-1:0]                div_src  [QW];
   logic [SW-1:0]                side_src [QW];

   logic [LANES-1:0][DW-1:0]     rem_in   [QW];
   logic [LANES-1:0][QW-1:0]     low_in   [QW];

   // Each stage reads the ports or the stage before it.
   always_comb begin
      valid_src[0] = in_valid;
      rem_src[0]   = in_rem;
      low_src[0]   = in_low;
      div_src[0]   = in_divisor;
      side_src[0]  = in_side;
      for (int k = 1; k < QW; k++) begin
         valid_src[k] = valid_ff[k-1];
         rem_src[k]   = rem_ff[k-1];
         low_src[k]   = low_ff[k-1];
         div_src[k]   = div_ff[k-1];
         side_src[k]  = side_ff[k-1];
      end
   end

   // One restoring step per stage: shift in the next dividend bit and
   // subtract the divisor when it fits; the quotient bit fills from the right.
   always_comb begin
      logic [DW:0] carry;
      logic [DW:0] trial;
      logic        qbit;
      for (int k = 0; k < QW; k++) begin
         for (int l = 0; l < LANES; l++) begin
            carry = {rem_src[k][l], low_src[k][l][QW-1]};
            trial = carry - {1'b0, div_src[k]};
            qbit  = ~trial[DW];
            if (qbit) begin
               rem_in[k][l] = trial[DW-1:0];
            end else begin
               rem_in[k][l] = carry[DW-1:0];
            end
            low_in[k][l] = {low_src[k][l][QW-2:0], qbit};
         end
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_src;
      end
   end

   // Payload.
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < QW; k++) begin
            rem_ff[k]  <= rem_in[k];
            low_ff[k]  <= low_in[k];
            div_ff[k]  <= div_src[k];
            side_ff[k] <= side_src[k];
         end
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_quot  = low_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule

>>> rtl/core/svpwm_duty_modulator.sv
// ----------------------------------------------------------------------------
// SVPWM duty modulator with min/max injection
// One word per cycle is accepted while the result side takes words, set by
// the fully pipelined dividers.
// Reset clears all valid bits and sets the ceiling register to one.
// ----------------------------------------------------------------------------
`include "svpwm_duty_modulator_macros.svh"

module svpwm_duty_modulator (
   input  logic                    clock,
   input  logic                    reset,
   // Configuration port.
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [15:0]             csr_ceiling_fraction,
   // Request channel.
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [15:0]      req_alpha_voltage,
   input  logic signed [15:0]      req_beta_voltage,
   input  logic signed [15:0]      req_bus_voltage,
   // Response channel.
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [15:0]             rsp_duty_a,
   output logic [15:0]             rsp_duty_b,
   output logic [15:0]             rsp_duty_c,
   output logic [15:0]             rsp_scale_factor,
   output logic                    rsp_bus_invalid
);

   localparam int LN = svpwm_pkg::LANES;
   localparam int DW = svpwm_pkg::DUTY_W;

   // The whole pipeline moves when the output register is free or taken.
   logic advance;
   logic rsp_valid_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   // Ceiling register.
   logic [svpwm_pkg::CEIL_W-1:0] ceiling_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ceiling_ff <= svpwm_pkg::Q15_ONE;
      end else if (csr_valid) begin
         ceiling_ff <= csr_ceiling_fraction;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: beta times sqrt(3)/2, ceiling saturated to one.
   // ------------------------------------------------------------------
   logic                           s1_valid_ff;
   logic signed [15:0]             s1_alpha_ff;
   svpwm_pkg::phase_type           s1_kbeta_ff;
   svpwm_pkg::phase_type           s1_kbeta_in;
   logic [15:0]                    s1_bus_ff;
   logic [svpwm_pkg::CEIL_W-1:0]   s1_ceil_ff;
   logic [svpwm_pkg::CEIL_W-1:0]   s1_ceil_in;

   always_comb begin
      s1_kbeta_in = svpwm_pkg::phase_type'(req_beta_voltage)
                  * svpwm_pkg::phase_type'(svpwm_pkg::SQRT3_HALF_Q16);
      s1_ceil_in  = (ceiling_ff > svpwm_pkg::Q15_ONE) ? svpwm_pkg::Q15_ONE : ceiling_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_alpha_ff <= req_alpha_voltage;
         s1_kbeta_ff <= s1_kbeta_in;
         s1_bus_ff   <= req_bus_voltage;
         s1_ceil_ff  <= s1_ceil_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: inverse Clarke in Q.16, available span ceiling * bus.
   // ------------------------------------------------------------------
   logic                              s2_valid_ff;
   svpwm_pkg::phase_type              s2_pa_ff, s2_pb_ff, s2_pc_ff;
   svpwm_pkg::phase_type              s2_pa_in, s2_pb_in, s2_pc_in;
   svpwm_pkg::phase_type              s2_half_a;
   logic [svpwm_pkg::AVAIL_W-1:0]     s2_avail_ff, s2_avail_in;
   logic [svpwm_pkg::BUS_W-1:0]       s2_bus_ff;
   logic                              s2_invalid_ff, s2_invalid_in;
   logic [svpwm_pkg::CEIL_W-1:0]      s2_ceil_ff;

   always_comb begin
      s2_pa_in      = svpwm_pkg::phase_type'(s1_alpha_ff) <<< 16;
      s2_half_a     = svpwm_pkg::phase_type'(s1_alpha_ff) <<< 15;
      s2_pb_in      = s1_kbeta_ff - s2_half_a;
      s2_pc_in      = -s2_half_a - s1_kbeta_ff;
      s2_avail_in   = (svpwm_pkg::AVAIL_W'(s1_ceil_ff)
                     * svpwm_pkg::AVAIL_W'(s1_bus_ff[svpwm_pkg::BUS_W-1:0])) << 1;
      s2_invalid_in = s1_bus_ff[15] || (s1_bus_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_pa_ff      <= s2_pa_in;
         s2_pb_ff      <= s2_pb_in;
         s2_pc_ff      <= s2_pc_in;
         s2_avail_ff   <= s2_avail_in;
         s2_bus_ff     <= s1_bus_ff[svpwm_pkg::BUS_W-1:0];
         s2_invalid_ff <= s2_invalid_in;
         s2_ceil_ff    <= s1_ceil_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: highest and lowest phase.
   // ------------------------------------------------------------------
   logic                              s3_valid_ff;
   svpwm_pkg::phase_type              s3_pa_ff, s3_pb_ff, s3_pc_ff;
   svpwm_pkg::phase_type              s3_hi_ff, s3_lo_ff, s3_hi_in, s3_lo_in;
   logic [svpwm_pkg::AVAIL_W-1:0]     s3_avail_ff;
   logic [svpwm_pkg::BUS_W-1:0]       s3_bus_ff;
   logic                              s3_invalid_ff;
   logic [svpwm_pkg::CEIL_W-1:0]      s3_ceil_ff;

   always_comb begin
      s3_hi_in = (s2_pa_ff > s2_pb_ff) ? s2_pa_ff : s2_pb_ff;
      s3_lo_in = (s2_pa_ff < s2_pb_ff) ? s2_pa_ff : s2_pb_ff;
      if (s2_pc_ff > s3_hi_in) begin
         s3_hi_in = s2_pc_ff;
      end
      if (s2_pc_ff < s3_lo_in) begin
         s3_lo_in = s2_pc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_pa_ff      <= s2_pa_ff;
         s3_pb_ff      <= s2_pb_ff;
         s3_pc_ff      <= s2_pc_ff;
         s3_hi_ff      <= s3_hi_in;
         s3_lo_ff      <= s3_lo_in;
         s3_avail_ff   <= s2_avail_ff;
         s3_bus_ff     <= s2_bus_ff;
         s3_invalid_ff <= s2_invalid_ff;
         s3_ceil_ff    <= s2_ceil_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: span and each phase above the lowest one.
   // ------------------------------------------------------------------
   logic                                 s4_valid_ff;
   svpwm_pkg::span_type                  s4_span_ff, s4_span_in;
   logic [LN-1:0][svpwm_pkg::SPAN_W-1:0] s4_diff_ff, s4_diff_in;
   logic [svpwm_pkg::AVAIL_W-1:0]        s4_avail_ff;
   logic [svpwm_pkg::BUS_W-1:0]          s4_bus_ff;
   logic                                 s4_invalid_ff;
   logic [svpwm_pkg::CEIL_W-1:0]         s4_ceil_ff;

   always_comb begin
      s4_span_in    = svpwm_pkg::span_type'(s3_hi_ff - s3_lo_ff);
      s4_diff_in[0] = svpwm_pkg::span_type'(s3_pa_ff - s3_lo_ff);
      s4_diff_in[1] = svpwm_pkg::span_type'(s3_pb_ff - s3_lo_ff);
      s4_diff_in[2] = svpwm_pkg::span_type'(s3_pc_ff - s3_lo_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_span_ff    <= s4_span_in;
         s4_diff_ff    <= s4_diff_in;
         s4_avail_ff   <= s3_avail_ff;
         s4_bus_ff     <= s3_bus_ff;
         s4_invalid_ff <= s3_invalid_ff;
         s4_ceil_ff    <= s3_ceil_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: does the vector need scaling down?
   // ------------------------------------------------------------------
   logic                                 s5_valid_ff;
   logic                                 s5_need_ff, s5_need_in;
   svpwm_pkg::span_type                  s5_span_ff;
   logic [LN-1:0][svpwm_pkg::SPAN_W-1:0] s5_diff_ff;
   logic [svpwm_pkg::AVAIL_W-1:0]        s5_avail_ff;
   logic [svpwm_pkg::BUS_W-1:0]          s5_bus_ff;
   logic                                 s5_invalid_ff;
   logic [svpwm_pkg::CEIL_W-1:0]         s5_ceil_ff;

   assign s5_need_in = s4_span_ff > svpwm_pkg::span_type'(s4_avail_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         s5_need_ff    <= s5_need_in;
         s5_span_ff    <= s4_span_ff;
         s5_diff_ff    <= s4_diff_ff;
         s5_avail_ff   <= s4_avail_ff;
         s5_bus_ff     <= s4_bus_ff;
         s5_invalid_ff <= s4_invalid_ff;
         s5_ceil_ff    <= s4_ceil_ff;
      end
   end

   // ------------------------------------------------------------------
   // Scale divider: avail * 32768 / span, 15 quotient bits.
   // ------------------------------------------------------------------
   logic [0:0][svpwm_pkg::SPAN_W-1:0]    sdiv_rem;
   logic [0:0][svpwm_pkg::SCALE_Q_W-1:0] sdiv_low;
   svpwm_pkg::span_type                  sdiv_divisor;
   svpwm_pkg::scale_side_type            sdiv_side_in, sdiv_side_out;
   logic                                 sdiv_valid_out;
   logic [0:0][svpwm_pkg::SCALE_Q_W-1:0] sdiv_quot;

   always_comb begin
      sdiv_rem[0]  = s5_need_ff ? svpwm_pkg::span_type'(s5_avail_ff) : '0;
      sdiv_low[0]  = '0;
      sdiv_divisor = s5_need_ff ? s5_span_ff : svpwm_pkg::span_type'(1);
      sdiv_side_in.need_scale  = s5_need_ff;
      sdiv_side_in.diff        = s5_diff_ff;
      sdiv_side_in.bus         = s5_bus_ff;
      sdiv_side_in.bus_invalid = s5_invalid_ff;
      sdiv_side_in.ceiling     = s5_ceil_ff;
   end

   svpwm_div_pipe #(
      .LANES (1),
      .DW    (svpwm_pkg::SPAN_W),
      .QW    (svpwm_pkg::SCALE_Q_W),
      .SW    (svpwm_pkg::SCALE_SIDE_W)
   ) u_scale_div (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (s5_valid_ff),
      .in_rem     (sdiv_rem),
      .in_low     (sdiv_low),
      .in_divisor (sdiv_divisor),
      .in_side    (sdiv_side_in),
      .out_valid  (sdiv_valid_out),
      .out_quot   (sdiv_quot),
      .out_side   (sdiv_side_out)
   );

   // ------------------------------------------------------------------
   // Stage 6: pick the scale and multiply each phase difference by it.
   // ------------------------------------------------------------------
   logic                                 s6_valid_ff;
   logic [DW-1:0]                        s6_scale_ff, s6_scale_in;
   logic [LN-1:0][svpwm_pkg::PROD_W-1:0] s6_prod_ff, s6_prod_in;
   logic [svpwm_pkg::BUS_W-1:0]          s6_bus_ff;
   logic                                 s6_invalid_ff;
   logic [svpwm_pkg::CEIL_W-1:0]         s6_ceil_ff;

   always_comb begin
      s6_scale_in = sdiv_side_out.need_scale ? {1'b0, sdiv_quot[0]} : svpwm_pkg::Q15_ONE;
      for (int l = 0; l < LN; l++) begin
         s6_prod_in[l] = svpwm_pkg::PROD_W'(sdiv_side_out.diff[l])
                       * svpwm_pkg::PROD_W'(s6_scale_in);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s6_scale_ff   <= s6_scale_in;
         s6_prod_ff    <= s6_prod_in;
         s6_bus_ff     <= sdiv_side_out.bus;
         s6_invalid_ff <= sdiv_side_out.bus_invalid;
         s6_ceil_ff    <= sdiv_side_out.ceiling;
      end
   end

   // ------------------------------------------------------------------
   // Duty dividers: (diff * scale) / (bus * 2^16), three lanes.
   // ------------------------------------------------------------------
   logic [LN-1:0][svpwm_pkg::BUS_W-1:0]    ddiv_rem;
   logic [LN-1:0][svpwm_pkg::DUTY_Q_W-1:0] ddiv_low;
   svpwm_pkg::duty_side_type               ddiv_side_in, ddiv_side_out;
   logic                                   ddiv_valid_out;
   logic [LN-1:0][svpwm_pkg::DUTY_Q_W-1:0] ddiv_quot;

   // The product shifted down by 16 is below bus * 2^16, so its upper part
   // already fits under the divisor.
   always_comb begin
      for (int l = 0; l < LN; l++) begin
         ddiv_rem[l] = s6_prod_ff[l][32 +: svpwm_pkg::BUS_W];
         ddiv_low[l] = s6_prod_ff[l][16 +: svpwm_pkg::DUTY_Q_W];
      end
      ddiv_side_in.scale       = s6_scale_ff;
      ddiv_side_in.bus_invalid = s6_invalid_ff;
      ddiv_side_in.ceiling     = s6_ceil_ff;
   end

   svpwm_div_pipe #(
      .LANES (LN),
      .DW    (svpwm_pkg::BUS_W),
      .QW    (svpwm_pkg::DUTY_Q_W),
      .SW    (svpwm_pkg::DUTY_SIDE_W)
   ) u_duty_div (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (s6_valid_ff),
      .in_rem     (ddiv_rem),
      .in_low     (ddiv_low),
      .in_divisor (s6_bus_ff),
      .in_side    (ddiv_side_in),
      .out_valid  (ddiv_valid_out),
      .out_quot   (ddiv_quot),
      .out_side   (ddiv_side_out)
   );

   // ------------------------------------------------------------------
   // Stage 7: pulse width is the quotient of the highest phase.
   // ------------------------------------------------------------------
   logic                                   s7_valid_ff;
   logic [LN-1:0][svpwm_pkg::DUTY_Q_W-1:0] s7_quot_ff;
   logic [DW-1:0]                          s7_width_ff, s7_width_in;
   logic [DW-1:0]                          s7_scale_ff;
   logic                                   s7_invalid_ff;
   logic [svpwm_pkg::CEIL_W-1:0]           s7_ceil_ff;

   always_comb begin
      s7_width_in = ddiv_quot[0];
      for (int l = 1; l < LN; l++) begin
         if (ddiv_quot[l] > s7_width_in) begin
            s7_width_in = ddiv_quot[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s7_quot_ff    <= ddiv_quot;
         s7_width_ff   <= s7_width_in;
         s7_scale_ff   <= ddiv_side_out.scale;
         s7_invalid_ff <= ddiv_side_out.bus_invalid;
         s7_ceil_ff    <= ddiv_side_out.ceiling;
      end
   end

   // ------------------------------------------------------------------
   // Stage 8: common-mode offset, centered and held under the ceiling.
   // ------------------------------------------------------------------
   logic                                   s8_valid_ff;
   logic [LN-1:0][svpwm_pkg::DUTY_Q_W-1:0] s8_quot_ff;
   logic [DW-1:0]                          s8_offset_ff, s8_offset_in;
   logic [DW-1:0]                          s8_scale_ff;
   logic                                   s8_invalid_ff;
   logic [DW-1:0]                          s8_width_sat;
   logic [DW:0]                            s8_center;
   logic signed [DW+1:0]                   s8_room;

   always_comb begin
      s8_width_sat = (s7_width_ff > svpwm_pkg::Q15_ONE) ? svpwm_pkg::Q15_ONE : s7_width_ff;
      s8_center    = ({1'b0, svpwm_pkg::Q15_ONE} - {1'b0, s8_width_sat}) >> 1;
      s8_room      = $signed({2'b00, s7_ceil_ff}) - $signed({2'b00, s8_width_sat});
      if (s8_room < 0) begin
         s8_offset_in = '0;
      end else if ($signed({1'b0, s8_center}) > s8_room) begin
         s8_offset_in = s8_room[DW-1:0];
      end else begin
         s8_offset_in = s8_center[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s8_quot_ff    <= s7_quot_ff;
         s8_offset_ff  <= s8_offset_in;
         s8_scale_ff   <= s7_scale_ff;
         s8_invalid_ff <= s7_invalid_ff;
      end
   end

   // ------------------------------------------------------------------
   // Output register: offset plus each phase, saturated to one, or zero for a bad bus.
   // ------------------------------------------------------------------
   logic [LN-1:0][DW-1:0] out_duty_ff, out_duty_in;
   logic [DW-1:0]         out_scale_ff, out_scale_in;
   logic                  out_invalid_ff;
   logic [DW:0]           out_sum;

   always_comb begin
      for (int l = 0; l < LN; l++) begin
         out_sum = {1'b0, s8_offset_ff} + {1'b0, s8_quot_ff[l]};
         if (s8_invalid_ff) begin
            out_duty_in[l] = '0;
         end else if (out_sum > {1'b0, svpwm_pkg::Q15_ONE}) begin
            out_duty_in[l] = svpwm_pkg::Q15_ONE;
         end else begin
            out_duty_in[l] = out_sum[DW-1:0];
         end
      end
      if (s8_invalid_ff) begin
         out_scale_in = '0;
      end else if (s8_scale_ff > svpwm_pkg::Q15_ONE) begin
         out_scale_in = svpwm_pkg::Q15_ONE;
      end else begin
         out_scale_in = s8_scale_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_duty_ff    <= out_duty_in;
         out_scale_ff   <= out_scale_in;
         out_invalid_ff <= s8_invalid_ff;
      end
   end

   // Valid bits of the stages outside the dividers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         s8_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         s6_valid_ff  <= sdiv_valid_out;
         s7_valid_ff  <= ddiv_valid_out;
         s8_valid_ff  <= s7_valid_ff;
         rsp_valid_ff <= s8_valid_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_duty_a       = out_duty_ff[0];
   assign rsp_duty_b       = out_duty_ff[1];
   assign rsp_duty_c       = out_duty_ff[2];
   assign rsp_scale_factor = out_scale_ff;
   assign rsp_bus_invalid  = out_invalid_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   // Conditions the checks below refer to.
   logic rsp_flagged;
   logic rsp_zeroed;
   logic rsp_good;
   logic rsp_low_half;
   logic s5_scaling;
   logic s8_held;

   assign rsp_flagged  = rsp_valid && rsp_bus_invalid;
   assign rsp_zeroed   = (rsp_duty_a == '0) && (rsp_duty_b == '0) && (rsp_duty_c == '0)
                       && (rsp_scale_factor == '0);
   assign rsp_good     = rsp_valid && !rsp_bus_invalid;
   assign rsp_low_half = (rsp_duty_a <= svpwm_pkg::Q15_HALF)
                       || (rsp_duty_b <= svpwm_pkg::Q15_HALF)
                       || (rsp_duty_c <= svpwm_pkg::Q15_HALF);
   assign s5_scaling   = s5_valid_ff && s5_need_ff;
   assign s8_held      = s8_valid_ff && !advance;

   `SVPWM_ASSERT_HOLDS(a_invalid_zero, clock, reset, rsp_flagged |-> rsp_zeroed, "Flagged word not zero.")
   `SVPWM_ASSERT_HOLDS(a_min_phase_offset, clock, reset, rsp_good |-> rsp_low_half, "Lowest duty over half.")
   `SVPWM_ASSERT_HOLDS(a_scale_divisor, clock, reset, s5_scaling |-> (s5_span_ff != '0), "Zero span divisor.")
   `SVPWM_ASSERT_NEXT(a_stall_offset, clock, reset, s8_held, $stable(s8_offset_ff), "Offset moved in a stall.")
   `SVPWM_ASSERT_NEXT(a_stall_quot, clock, reset, s8_held, $stable(s8_quot_ff), "Phases moved in a stall.")

endmodule

>>> sim/svpwm_duty_modulator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SVPWM duty modulator testbench
// Sends alpha/beta/bus voltage words through the modulator and checks every
// result word against a cycle-free predictor of the min/max injection math.
// Directed tests cover the field extremes, a bus that is not positive, and
// ceiling settings of zero, one and above one. A long random test follows.
// Both handshake sides pause at random, with stretches at full rate.
// ----------------------------------------------------------------------------
module svpwm_duty_modulator_tb;

   // One result word as the block reports it.
   typedef struct packed {
      logic [15:0] duty_a;
      logic [15:0] duty_b;
      logic [15:0] duty_c;
      logic [15:0] scale_factor;
      logic        bus_invalid;
   } duty_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [15:0]        csr_ceiling_fraction = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [15:0] req_alpha_voltage = '0;
   logic signed [15:0] req_beta_voltage = '0;
   logic signed [15:0] req_bus_voltage = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b1;
   logic [15:0]        rsp_duty_a;
   logic [15:0]        rsp_duty_b;
   logic [15:0]        rsp_duty_c;
   logic [15:0]        rsp_scale_factor;
   logic               rsp_bus_invalid;

   // Duties still owed by the block, oldest first.
   duty_result_type expected_duties[$];
   logic [15:0]     ceiling_setting = svpwm_pkg::Q15_ONE;
   int              idle_max = 6;
   int              error_count = 0;
   int              vectors_sent = 0;
   int              results_checked = 0;
   int              ceiling_writes = 0;
   int              invalid_bus_seen = 0;

   svpwm_duty_modulator dut (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_ceiling_fraction (csr_ceiling_fraction),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_alpha_voltage    (req_alpha_voltage),
      .req_beta_voltage     (req_beta_voltage),
      .req_bus_voltage      (req_bus_voltage),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_duty_a           (rsp_duty_a),
      .rsp_duty_b           (rsp_duty_b),
      .rsp_duty_c           (rsp_duty_c),
      .rsp_scale_factor     (rsp_scale_factor),
      .rsp_bus_invalid      (rsp_bus_invalid)
   );

   // Free-running clock with a 12 ns period.
   always #6 clock = ~clock;

   // Works out the duties for one vector. Phases are kept in Q.16 volts and
   // every quotient truncates, as the divider pipeline does.
   function automatic duty_result_type predict_duties(input logic signed [15:0] alpha_v,
                                                      input logic signed [15:0] beta_v,
                                                      input logic signed [15:0] bus_v,
                                                      input logic [15:0] ceiling_reg);
      duty_result_type r;
      longint          ceil_q, bus, pa, pb, pc, hi, lo, span, avail;
      longint          scale, denom, width, offset, room, da, db, dc, one;
      one = longint'(svpwm_pkg::Q15_ONE);
      r = '0;
      if (bus_v <= 0) begin
         r.bus_invalid = 1'b1;
         return r;
      end
      // A ceiling above one behaves as one.
      ceil_q = (ceiling_reg > svpwm_pkg::Q15_ONE) ? one : longint'(ceiling_reg);
      bus = longint'(bus_v);
      // Inverse Clarke step.
      pa = longint'(alpha_v) * 65536;
      pb = longint'(alpha_v) * -32768
         + longint'(beta_v) * longint'(svpwm_pkg::SQRT3_HALF_Q16);
      pc = longint'(alpha_v) * -32768
         - longint'(beta_v) * longint'(svpwm_pkg::SQRT3_HALF_Q16);
      hi = (pa > pb) ? pa : pb;
      lo = (pa < pb) ? pa : pb;
      if (pc > hi) hi = pc;
      if (pc < lo) lo = pc;
      span = hi - lo;
      // Scale the vector down when its span does not fit under the ceiling.
      avail = ceil_q * bus * 2;
      scale = one;
      if (span > avail) scale = (avail * one) / span;
      denom = bus * 65536;
      width = (span * scale) / denom;
      if (width > one) width = one;
      // Center on one half, then push down under the ceiling, never below zero.
      offset = (one - width) >>> 1;
      room = ceil_q - width;
      if (offset > room) offset = room;
      if (offset < 0) offset = 0;
      da = offset + ((pa - lo) * scale) / denom;
      db = offset + ((pb - lo) * scale) / denom;
      dc = offset + ((pc - lo) * scale) / denom;
      r.duty_a = 16'((da > one) ? one : da);
      r.duty_b = 16'((db > one) ? one : db);
      r.duty_c = 16'((dc > one) ? one : dc);
      r.scale_factor = 16'((scale > one) ? one : scale);
      return r;
   endfunction

   // Offers one vector word and records its expected duties once accepted.
   // Valid stays high into the next word when no gap is drawn.
   task automatic send_vector(input logic signed [15:0] alpha_v,
                              input logic signed [15:0] beta_v,
                              input logic signed [15:0] bus_v);
      int gap;
      gap = $urandom_range(0, idle_max);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_alpha_voltage <= alpha_v;
      req_beta_voltage  <= beta_v;
      req_bus_voltage   <= bus_v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_duties.push_back(predict_duties(alpha_v, beta_v, bus_v, ceiling_setting));
      vectors_sent++;
   endtask

   // Stops sending and waits until every owed result word has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_duties.size() != 0) @(posedge clock);
   endtask

   // Writes the ceiling register; the block must be idle.
   task automatic write_ceiling(input logic [15:0] value);
      csr_valid            <= 1'b1;
      csr_ceiling_fraction <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid       <= 1'b0;
      ceiling_setting  = value;
      ceiling_writes++;
   endtask

   // Field extremes and the zero vector at the reset ceiling of one.
   task automatic test_reset_ceiling();
      send_vector(16'sd0, 16'sd0, 16'sd12800);
      send_vector(16'sd3200, 16'sd0, 16'sd12800);
      send_vector(16'sd0, 16'sd5000, 16'sd12800);
      send_vector(16'sd32767, 16'sd0, 16'sd1);
      send_vector(-16'sd32768, 16'sd32767, 16'sd1);
      send_vector(-16'sd32768, -16'sd32768, 16'sd32767);
      send_vector(16'sd32767, 16'sd32767, 16'sd32767);
      send_vector(16'sd100, -16'sd100, 16'sd32767);
      drain_results();
   endtask

   // A bus of zero or below flags the word and zeroes the duties.
   task automatic test_bus_not_positive();
      send_vector(16'sd1000, 16'sd1000, 16'sd0);
      send_vector(16'sd0, 16'sd0, -16'sd1);
      send_vector(16'sd32767, -16'sd32768, -16'sd32768);
      drain_results();
   endtask

   // Ceiling of zero, above one, just above one and the smallest step.
   task automatic test_ceiling_extremes();
      write_ceiling(16'd0);
      send_vector(16'sd0, 16'sd0, 16'sd1000);
      send_vector(16'sd500, 16'sd200, 16'sd1000);
      drain_results();
      write_ceiling(16'hFFFF);
      send_vector(16'sd0, 16'sd0, 16'sd256);
      send_vector(16'sd2000, -16'sd3000, 16'sd256);
      drain_results();
      write_ceiling(16'd32769);
      send_vector(-16'sd32768, 16'sd0, 16'sd32767);
      drain_results();
      write_ceiling(16'd1);
      send_vector(16'sd0, 16'sd0, 16'sd100);
      send_vector(16'sd1, 16'sd1, 16'sd32767);
      drain_results();
   endtask

   // Random vectors over a series of ceiling settings. Most words carry a
   // positive bus and a vector near the bus size so that both the scaled and
   // the unscaled paths are taken; the rest use full-range fields.
   task automatic test_random_traffic();
      logic [15:0]        ceiling_plan [0:7];
      logic signed [15:0] alpha_v, beta_v, bus_v;
      int                 kind, limit;
      ceiling_plan = '{16'd32768, 16'd0, 16'd65535, 16'd16384,
                       16'd29491, 16'd0, 16'd1, 16'd32767};
      ceiling_plan[5] = 16'($urandom_range(2, 32766));
      for (int phase = 0; phase < 8; phase++) begin
         write_ceiling(ceiling_plan[phase]);
         for (int n = 0; n < 132; n++) begin
            // Alternate between paced traffic and full-rate stretches.
            if (n % 33 == 0) idle_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
            // Once, hold off until the pipeline is empty.
            if (phase == 3 && n == 66) drain_results();
            kind = $urandom_range(0, 99);
            if (kind < 3)
               bus_v = 16'sd0;
            else if (kind < 12)
               bus_v = 16'($urandom);
            else
               bus_v = 16'($urandom_range(1, (kind % 2) ? 32767 : 600));
            if (kind < 40 || bus_v <= 0) begin
               alpha_v = 16'($urandom);
               beta_v  = 16'($urandom);
            end else begin
               limit   = int'(bus_v);
               alpha_v = 16'(int'($urandom_range(0, 2 * limit)) - limit);
               beta_v  = 16'(int'($urandom_range(0, 2 * limit)) - limit);
            end
            send_vector(alpha_v, beta_v, bus_v);
         end
         drain_results();
      end
      idle_max = 6;
   endtask

   // Result side: random stalls, and a field-by-field check of every word.
   initial begin : result_checker
      duty_result_type seen, want;
      int              stall;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            seen = '{rsp_duty_a, rsp_duty_b, rsp_duty_c, rsp_scale_factor, rsp_bus_invalid};
            results_checked++;
            if (seen.bus_invalid) invalid_bus_seen++;
            if (expected_duties.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: result word with nothing expected: %p", $realtime, seen);
            end else begin
               want = expected_duties.pop_front();
               if (seen.duty_a !== want.duty_a || seen.duty_b !== want.duty_b ||
                   seen.duty_c !== want.duty_c ||
                   seen.scale_factor !== want.scale_factor ||
                   seen.bus_invalid !== want.bus_invalid) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("%0t: mismatch expected %p actual %p",
                              $realtime, want, seen);
               end
            end
            stall = $urandom_range(0, idle_max);
            if (stall != 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   // Run limit, far above the slowest legal run.
   initial begin : run_limit
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // Reset, the tests in turn, then the final verdict.
   initial begin : test_sequence
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_ceiling();
      test_bus_not_positive();
      test_ceiling_extremes();
      test_random_traffic();
      drain_results();
      // Give any stray word time to show up past the pipeline latency.
      repeat (60) @(posedge clock);
      $display("Sent %0d vector words, checked %0d result words (%0d with a bad bus).",
               vectors_sent, results_checked, invalid_bus_seen);
      $display("Ceiling written %0d times, from zero through above one; %0d errors.",
               ceiling_writes, error_count);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/svpwm_pkg.sv
rtl/core/svpwm_div_pipe.sv
rtl/core/svpwm_duty_modulator.sv
sim/svpwm_duty_modulator_tb.sv
